/* design/rwl_pkg.sv */
// ----------------------------------------------------------------------------
// rwl_pkg
// Shared types and constants of the reader-writer lock arbiter.
// ----------------------------------------------------------------------------
package rwl_pkg;

   localparam int IdFieldW = 8;
   localparam int ReadersW = 9;
   localparam logic [ReadersW-1:0] READERS_MAX = 9'd511;

   typedef enum logic [1:0] {
      OP_ENTER_READ  = 2'd0,
      OP_EXIT_READ   = 2'd1,
      OP_ENTER_WRITE = 2'd2,
      OP_EXIT_WRITE  = 2'd3
   } rwl_op_type;

   typedef enum logic [2:0] {
      ST_GRANTED  = 3'd0,
      ST_QUEUED   = 3'd1,
      ST_RELEASED = 3'd2,
      ST_NOT_HELD = 3'd3,
      ST_FULL     = 3'd4
   } rwl_status_type;

   localparam logic KIND_SELF  = 1'b0;
   localparam logic KIND_WOKEN = 1'b1;

   // Commands from the arbiter to one wait queue.
   typedef struct packed {
      logic push;   // append the incoming id at the tail
      logic fetch;  // start a read of the head entry
      logic pop;    // drop the head entry and read the next one
   } rwl_q_ctl_type;

   // Occupancy flags of one wait queue.
   typedef struct packed {
      logic full;
      logic empty;
      logic single;
   } rwl_q_status_type;

endpackage

/* design/rwl_channels.sv */
// ----------------------------------------------------------------------------
// rwl_channels
// Valid/ready channels for lock requests and lock results.
// ----------------------------------------------------------------------------
interface rwl_req_if;
   import rwl_pkg::*;

   logic                valid;
   logic                ready;
   logic [1:0]          req_type;
   logic [IdFieldW-1:0] requester_id;

   modport source (output valid, req_type, requester_id, input ready);
   modport sink   (input valid, req_type, requester_id, output ready);
endinterface

interface rwl_rsp_if;
   import rwl_pkg::*;

   logic                valid;
   logic                ready;
   logic                result_kind;
   logic [IdFieldW-1:0] client_id;
   logic                grant_as_writer;
   logic [2:0]          status;
   logic                last;

   modport source (output valid, result_kind, client_id, grant_as_writer, status, last,
                   input ready);
   modport sink   (input valid, result_kind, client_id, grant_as_writer, status, last,
                   output ready);
endinterface

/* design/rwl_ram.sv */
// ----------------------------------------------------------------------------
// rwl_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rwl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/rwl_queue.sv */
// ----------------------------------------------------------------------------
// rwl_queue
// Circular wait queue of requester ids kept in one RAM.
// ----------------------------------------------------------------------------
module rwl_queue #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rwl_pkg::rwl_q_ctl_type    ctl,
   input  logic [WIDTH-1:0]          push_id,
   output rwl_pkg::rwl_q_status_type status,
   output logic [WIDTH-1:0]          head_id
);
   import rwl_pkg::*;

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);

   logic [PtrW-1:0] head_ff, head_in;
   logic [PtrW-1:0] tail_ff, tail_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [PtrW-1:0] rd_addr;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (ctl.push) begin
         tail_in = (tail_ff == PtrLast) ? '0 : tail_ff + PtrW'(1);
      end
      if (ctl.pop) begin
         head_in = (head_ff == PtrLast) ? '0 : head_ff + PtrW'(1);
      end
      if (ctl.push && !ctl.pop) begin
         count_in = count_ff + CntW'(1);
      end else if (ctl.pop && !ctl.push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // A pop reads ahead at the new head so the next id is ready in the next cycle.
   assign rd_addr = ctl.pop ? head_in : head_ff;

   rwl_ram #(
      .WIDTH (WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctl.push),
      .wr_addr (tail_ff),
      .wr_data (push_id),
      .rd_en   (ctl.fetch || ctl.pop),
      .rd_addr (rd_addr),
      .rd_data (head_id)
   );

   assign status.full   = (count_ff == CntW'(DEPTH));
   assign status.empty  = (count_ff == '0);
   assign status.single = (count_ff == CntW'(1));

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      ctl.push |-> !status.full) else $error("push into a full wait queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      ctl.pop |-> !status.empty) else $error("pop from an empty wait queue");

endmodule

/* design/fifo_reader_writer_lock_arbiter.sv */
// ----------------------------------------------------------------------------
// fifo_reader_writer_lock_arbiter
// Reader-writer lock with first-come wait queues for readers and writers.
// ----------------------------------------------------------------------------
// Each request beat carries an operation (enter/exit, read/write) and a
// requester id, of which the low ID_WIDTH bits are kept. Every request answers
// with one status beat for the requester itself, followed by one beat for each
// waiter that the request wakes; the last beat of a request has last set. A
// reader enters at once unless a writer is active or waiting, and a writer
// enters only when the lock is free; otherwise the requester is queued, or
// refused with a queue-full status when its queue already holds QUEUE_DEPTH
// ids. When the last reader leaves, the oldest waiting writer is granted. When
// a writer leaves, all queued readers are granted in arrival order, or, with
// no reader waiting, the oldest writer. The waiting ids live in two RAMs with
// one read port each. The woken ids are read from the queue's RAM one per
// cycle and sent as one beat per cycle while the result channel takes them;
// a stall on the result channel holds them. Results sit in an output
// register, so a new request is taken while the previous one's last beat is
// being taken.
// ----------------------------------------------------------------------------
module fifo_reader_writer_lock_arbiter #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_WIDTH    = 8
) (
   input  logic      clock,
   input  logic      reset,
   rwl_req_if.sink   req_ch,
   rwl_rsp_if.source rsp_ch
);
   import rwl_pkg::*;

   // Ids never exceed the 8-bit field, so the stored width stops there.
   localparam int KeepW = (ID_WIDTH < IdFieldW) ? ID_WIDTH : IdFieldW;

   typedef enum logic {
      S_IDLE,
      S_WAKE
   } state_type;

   state_type            state_ff, state_in;
   logic [ReadersW-1:0]  readers_ff, readers_in;
   logic                 writer_ff, writer_in;
   logic                 wake_readers_ff, wake_readers_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 kind_ff, kind_in;
   logic [IdFieldW-1:0]  client_ff, client_in;
   logic                 as_writer_ff, as_writer_in;
   rwl_status_type       status_ff, status_in;
   logic                 last_ff, last_in;

   rwl_q_ctl_type        rq_ctl, wq_ctl;
   rwl_q_status_type     rq_st, wq_st;
   logic [KeepW-1:0]     rq_head, wq_head;
   logic [KeepW-1:0]     id_kept;
   logic [KeepW-1:0]     woken_id;

   logic                 slot_free;
   logic                 accept;
   logic                 wake_go;
   rwl_op_type           op;

   // The output register can be loaded when empty or when its beat leaves now.
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE) && slot_free;
   assign accept  = req_ch.valid && req_ch.ready;
   assign wake_go = (state_ff == S_WAKE) && slot_free;
   assign op      = rwl_op_type'(req_ch.req_type);
   assign id_kept = req_ch.requester_id[KeepW-1:0];
   assign woken_id = wake_readers_ff ? rq_head : wq_head;

   // Pushes only happen on enter requests and reads only on exit requests or
   // while waking, so a queue never sees a write and a read of one entry at once.
   always_comb begin
      state_in        = state_ff;
      readers_in      = readers_ff;
      writer_in       = writer_ff;
      wake_readers_in = wake_readers_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;
      kind_in         = kind_ff;
      client_in       = client_ff;
      as_writer_in    = as_writer_ff;
      status_in       = status_ff;
      last_in         = last_ff;
      rq_ctl          = '0;
      wq_ctl          = '0;

      if (accept) begin
         rsp_valid_in = 1'b1;
         kind_in      = KIND_SELF;
         client_in    = IdFieldW'(id_kept);
         as_writer_in = (op == OP_ENTER_WRITE) || (op == OP_EXIT_WRITE);
         status_in    = ST_GRANTED;
         last_in      = 1'b1;

         unique case (op)
            OP_ENTER_READ: begin
               if (!writer_ff && wq_st.empty) begin
                  if (readers_ff == READERS_MAX) begin
                     status_in = ST_FULL;
                  end else begin
                     readers_in = readers_ff + ReadersW'(1);
                  end
               end else if (!rq_st.full) begin
                  rq_ctl.push = 1'b1;
                  status_in   = ST_QUEUED;
               end else begin
                  status_in = ST_FULL;
               end
            end
            OP_EXIT_READ: begin
               if (readers_ff == '0) begin
                  status_in = ST_NOT_HELD;
               end else begin
                  readers_in = readers_ff - ReadersW'(1);
                  status_in  = ST_RELEASED;
                  if (readers_ff == ReadersW'(1) && !writer_ff && !wq_st.empty) begin
                     writer_in       = 1'b1;
                     wq_ctl.fetch    = 1'b1;
                     wake_readers_in = 1'b0;
                     last_in         = 1'b0;
                     state_in        = S_WAKE;
                  end
               end
            end
            OP_ENTER_WRITE: begin
               if (readers_ff == '0 && !writer_ff) begin
                  writer_in = 1'b1;
               end else if (!wq_st.full) begin
                  wq_ctl.push = 1'b1;
                  status_in   = ST_QUEUED;
               end else begin
                  status_in = ST_FULL;
               end
            end
            OP_EXIT_WRITE: begin
               if (!writer_ff) begin
                  status_in = ST_NOT_HELD;
               end else begin
                  writer_in = 1'b0;
                  status_in = ST_RELEASED;
                  if (!rq_st.empty) begin
                     rq_ctl.fetch    = 1'b1;
                     wake_readers_in = 1'b1;
                     last_in         = 1'b0;
                     state_in        = S_WAKE;
                  end else if (!wq_st.empty) begin
                     writer_in       = 1'b1;
                     wq_ctl.fetch    = 1'b1;
                     wake_readers_in = 1'b0;
                     last_in         = 1'b0;
                     state_in        = S_WAKE;
                  end
               end
            end
            default: begin
               status_in = ST_NOT_HELD;
            end
         endcase
      end else if (wake_go) begin
         // The head id already read from the RAM goes out; the pop reads the next one.
         rsp_valid_in = 1'b1;
         kind_in      = KIND_WOKEN;
         client_in    = IdFieldW'(woken_id);
         as_writer_in = !wake_readers_ff;
         status_in    = ST_GRANTED;
         if (wake_readers_ff) begin
            rq_ctl.pop = 1'b1;
            last_in    = rq_st.single;
            if (readers_ff != READERS_MAX) begin
               readers_in = readers_ff + ReadersW'(1);
            end
         end else begin
            wq_ctl.pop = 1'b1;
            last_in    = 1'b1;
         end
         if (last_in) begin
            state_in = S_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         readers_ff      <= '0;
         writer_ff       <= 1'b0;
         wake_readers_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         readers_ff      <= readers_in;
         writer_ff       <= writer_in;
         wake_readers_ff <= wake_readers_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      kind_ff      <= kind_in;
      client_ff    <= client_in;
      as_writer_ff <= as_writer_in;
      status_ff    <= status_in;
      last_ff      <= last_in;
   end

   rwl_queue #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (KeepW)
   ) u_reader_queue (
      .clock   (clock),
      .reset   (reset),
      .ctl     (rq_ctl),
      .push_id (id_kept),
      .status  (rq_st),
      .head_id (rq_head)
   );

   rwl_queue #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (KeepW)
   ) u_writer_queue (
      .clock   (clock),
      .reset   (reset),
      .ctl     (wq_ctl),
      .push_id (id_kept),
      .status  (wq_st),
      .head_id (wq_head)
   );

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.result_kind     = kind_ff;
   assign rsp_ch.client_id       = client_ff;
   assign rsp_ch.grant_as_writer = as_writer_ff;
   assign rsp_ch.status          = status_ff;
   assign rsp_ch.last            = last_ff;

   a_exclusive_hold: assert property (@(posedge clock) disable iff (reset)
      !(writer_ff && readers_ff != '0)) else $error("writer and readers hold the lock");

   a_wake_has_waiter: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAKE) |-> (wake_readers_ff ? !rq_st.empty : !wq_st.empty))
      else $error("waking from an empty queue");

   a_request_answered: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff && kind_ff == KIND_SELF)
      else $error("accepted request produced no status beat");

   a_woken_granted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff == KIND_WOKEN) |-> status_ff == ST_GRANTED)
      else $error("woken waiter beat without a grant");

endmodule
